// ===== src/can_bit_timing_solver_top_assert.svh =====
// Assertion macros for the CAN bit timing solver.
// Both expect a signal named clk in the including scope; BTS_ASSERT also needs rst_n.
`ifndef CAN_BIT_TIMING_SOLVER_TOP_ASSERT_SVH
`define CAN_BIT_TIMING_SOLVER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// checked outside reset
`define BTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define BTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BTS_ASSERT(lbl, prop, msg)
`define BTS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== src/can_bts_pkg.sv =====
`default_nettype none

package can_bts_pkg;

  localparam int unsigned QUANTA_MIN = 8;
  localparam int unsigned QUANTA_MAX = 25;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned CLOCK_HZ_RESET = 80000000;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RATE_ZERO = 2'd1,
    ST_NOT_MULT  = 2'd2,
    ST_NO_FIT    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK_GO,
    S_CHK_WAIT,
    S_TRY_GO,
    S_TRY_WAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] prop;
    logic [3:0] ph1;
    logic [3:0] ph2;
  } seg_t;

  // Segment split for ~87.5% sample point: ph1 = round(64*(q-1)/73),
  // excess above 8 into prop, rest to ph2. Only q = 11..19 give all
  // segments in 1..8.
  function automatic seg_t seg_split(input logic [4:0] q);
    seg_t s;
    s = '{ok: 1'b0, prop: 4'd0, ph1: 4'd0, ph2: 4'd0};
    case (q)
      5'd11: s = '{ok: 1'b1, prop: 4'd1, ph1: 4'd8, ph2: 4'd1};
      5'd12: s = '{ok: 1'b1, prop: 4'd2, ph1: 4'd8, ph2: 4'd1};
      5'd13: s = '{ok: 1'b1, prop: 4'd3, ph1: 4'd8, ph2: 4'd1};
      5'd14: s = '{ok: 1'b1, prop: 4'd3, ph1: 4'd8, ph2: 4'd2};
      5'd15: s = '{ok: 1'b1, prop: 4'd4, ph1: 4'd8, ph2: 4'd2};
      5'd16: s = '{ok: 1'b1, prop: 4'd5, ph1: 4'd8, ph2: 4'd2};
      5'd17: s = '{ok: 1'b1, prop: 4'd6, ph1: 4'd8, ph2: 4'd2};
      5'd18: s = '{ok: 1'b1, prop: 4'd7, ph1: 4'd8, ph2: 4'd2};
      5'd19: s = '{ok: 1'b1, prop: 4'd8, ph1: 4'd8, ph2: 4'd2};
      default: s = '{ok: 1'b0, prop: 4'd0, ph1: 4'd0, ph2: 4'd0};
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== src/can_bts_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module can_bts_div #(
  parameter int unsigned DW = 32
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  can_bts_pkg::div_req_t req,
  input  wire  [31:0]           dividend,
  input  wire  [DW-1:0]         divisor,
  output can_bts_pkg::div_stat_t stat,
  output logic [31:0]           quotient,
  output logic [31:0]           remainder
);
  import can_bts_pkg::*;

  localparam int unsigned CW = (DW > 33) ? DW : 33;

  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [31:0]   quo_r, quo_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dsr_r, dsr_nxt;

  logic [CW-1:0] shifted;
  logic [CW-1:0] dsr_ext;
  logic          ge;

  assign shifted = {rem_r[CW-2:0], quo_r[31]};
  assign dsr_ext = CW'(dsr_r);
  assign ge      = (shifted >= dsr_ext);

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      quo_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
    end else if (run_r) begin
      rem_nxt = ge ? (shifted - dsr_ext) : shifted;
      quo_nxt = {quo_r[30:0], ge};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(DIV_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat.busy = run_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r[31:0];

endmodule

`default_nettype wire

// ===== src/can_bit_timing_solver_top.sv =====
`default_nettype none

// CAN bit timing solver. Give it a bitrate word on the in_ channel and it
// returns one result word: a status (ok, bitrate zero, clock not a multiple
// of the bitrate, no valid setting), the packed timing register word and
// the separate prescaler, quanta-per-bit and segment lengths (all zero on
// error). The module clock in Hz sits in one register written through the
// cfg_ port (reset 80 MHz); write it only while no request is in flight.
// Prescalers 1..MAX_PRESCALER are tried in rising order and the first one
// where clock / (2 * prescaler * bitrate) is exact and gives a legal
// segment split wins. All remainders and quotients come from one shared
// 32-step restoring divider, so each division is a start, 32 steps and a
// done. A request runs the multiple-of-bitrate check, then one division
// per prescaler tried, then loads the result; the time from one request
// to the next grows while the result side stalls. The input stalls for
// the whole search; a finished result waits in the output register while
// the next request may already be taken.
module can_bit_timing_solver_top #(
  parameter int unsigned MAX_PRESCALER = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  // request
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [23:0] in_bitrate,
  // result
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_status,
  output logic [18:0] out_cfg_word,
  output logic [6:0]  out_prescaler,
  output logic [4:0]  out_quanta_per_bit,
  output logic [3:0]  out_prop_seg,
  output logic [3:0]  out_phase1_seg,
  output logic [3:0]  out_phase2_seg,
  // clock frequency register
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [31:0] cfg_clock_hz
);
  import can_bts_pkg::*;

  `include "can_bit_timing_solver_top_assert.svh"

  // prescaler counter width and 2*prescaler*bitrate width
  localparam int unsigned BW = $clog2(MAX_PRESCALER + 1);
  localparam int unsigned DW = 25 + BW;

  state_t        state_r, state_nxt;
  logic [31:0]   clock_hz_r, clock_hz_nxt;
  logic [23:0]   rate_r, rate_nxt;
  logic [BW-1:0] brp_r, brp_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;       // 2 * brp * rate
  status_t       res_status_r, res_status_nxt;
  logic [BW-1:0] res_brp_r, res_brp_nxt;
  logic [4:0]    res_q_r, res_q_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [18:0]   out_cfg_word_r, out_cfg_word_nxt;
  logic [6:0]    out_prescaler_r, out_prescaler_nxt;
  logic [4:0]    out_q_r, out_q_nxt;
  logic [3:0]    out_prop_r, out_prop_nxt;
  logic [3:0]    out_ph1_r, out_ph1_nxt;
  logic [3:0]    out_ph2_r, out_ph2_nxt;

  div_req_t      div_req;
  div_stat_t     div_stat;
  logic [DW-1:0] div_divisor;
  logic [31:0]   div_quo;
  logic [31:0]   div_rem;

  logic          in_acc;
  logic          out_load;
  logic [DW-1:0] two_rate;
  logic          trial_ok;
  logic          last_brp;
  seg_t          try_seg;
  seg_t          res_seg;
  logic [BW-1:0] res_brp_m1;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_FINISH) && (!out_valid_r || !out_stall);

  assign two_rate = DW'({rate_r, 1'b0});
  assign last_brp = (brp_r == BW'(MAX_PRESCALER));

  // shared divider: clock / bitrate first, then clock / (2*brp*bitrate)
  assign div_req.start = (state_r == S_CHK_GO) || (state_r == S_TRY_GO);
  assign div_divisor   = (state_r == S_CHK_GO) ? DW'(rate_r) : dvs_r;

  can_bts_div #(
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (clock_hz_r),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  assign try_seg  = seg_split(div_quo[4:0]);
  assign trial_ok = (div_rem == 32'd0)
                 && (div_quo >= 32'(QUANTA_MIN))
                 && (div_quo <= 32'(QUANTA_MAX))
                 && try_seg.ok;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_bitrate == 24'd0) ? S_FINISH : S_CHK_GO;
        end
      end
      S_CHK_GO:   state_nxt = S_CHK_WAIT;
      S_CHK_WAIT: begin
        if (div_stat.done) begin
          state_nxt = (div_rem != 32'd0) ? S_FINISH : S_TRY_GO;
        end
      end
      S_TRY_GO:   state_nxt = S_TRY_WAIT;
      S_TRY_WAIT: begin
        if (div_stat.done) begin
          state_nxt = (trial_ok || last_brp) ? S_FINISH : S_TRY_GO;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and result register
  assign res_seg    = seg_split(res_q_r);
  assign res_brp_m1 = res_brp_r - BW'(1);

  always_comb begin
    clock_hz_nxt   = clock_hz_r;
    rate_nxt       = rate_r;
    brp_nxt        = brp_r;
    dvs_nxt        = dvs_r;
    res_status_nxt = res_status_r;
    res_brp_nxt    = res_brp_r;
    res_q_nxt      = res_q_r;

    out_valid_nxt     = out_valid_r && out_stall;
    out_status_nxt    = out_status_r;
    out_cfg_word_nxt  = out_cfg_word_r;
    out_prescaler_nxt = out_prescaler_r;
    out_q_nxt         = out_q_r;
    out_prop_nxt      = out_prop_r;
    out_ph1_nxt       = out_ph1_r;
    out_ph2_nxt       = out_ph2_r;

    if (cfg_valid && cfg_ready) begin
      clock_hz_nxt = cfg_clock_hz;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rate_nxt       = in_bitrate;
          res_status_nxt = ST_RATE_ZERO;
        end
      end
      S_CHK_WAIT: begin
        if (div_stat.done) begin
          res_status_nxt = ST_NOT_MULT;
          brp_nxt        = BW'(1);
          dvs_nxt        = two_rate;
        end
      end
      S_TRY_WAIT: begin
        if (div_stat.done) begin
          if (trial_ok) begin
            res_status_nxt = ST_OK;
            res_brp_nxt    = brp_r;
            res_q_nxt      = div_quo[4:0];
          end else begin
            res_status_nxt = ST_NO_FIT;
            brp_nxt        = brp_r + BW'(1);
            dvs_nxt        = dvs_r + two_rate;
          end
        end
      end
      S_FINISH: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          if (res_status_r == ST_OK) begin
            out_cfg_word_nxt  = {res_seg.ph2[2:0] - 3'd1, 1'b1, 1'b0,
                                 res_seg.ph1[2:0] - 3'd1,
                                 res_seg.prop[2:0] - 3'd1, 2'b00,
                                 6'(res_brp_m1)};
            out_prescaler_nxt = 7'(res_brp_r);
            out_q_nxt         = res_q_r;
            out_prop_nxt      = res_seg.prop;
            out_ph1_nxt       = res_seg.ph1;
            out_ph2_nxt       = res_seg.ph2;
          end else begin
            out_cfg_word_nxt  = '0;
            out_prescaler_nxt = '0;
            out_q_nxt         = '0;
            out_prop_nxt      = '0;
            out_ph1_nxt       = '0;
            out_ph2_nxt       = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clock_hz_r  <= 32'(CLOCK_HZ_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clock_hz_r  <= clock_hz_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rate_r          <= rate_nxt;
    brp_r           <= brp_nxt;
    dvs_r           <= dvs_nxt;
    res_status_r    <= res_status_nxt;
    res_brp_r       <= res_brp_nxt;
    res_q_r         <= res_q_nxt;
    out_status_r    <= out_status_nxt;
    out_cfg_word_r  <= out_cfg_word_nxt;
    out_prescaler_r <= out_prescaler_nxt;
    out_q_r         <= out_q_nxt;
    out_prop_r      <= out_prop_nxt;
    out_ph1_r       <= out_ph1_nxt;
    out_ph2_r       <= out_ph2_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_cfg_word       = out_cfg_word_r;
  assign out_prescaler      = out_prescaler_r;
  assign out_quanta_per_bit = out_q_r;
  assign out_prop_seg       = out_prop_r;
  assign out_phase1_seg     = out_ph1_r;
  assign out_phase2_seg     = out_ph2_r;

  // checks
  `BTS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE) && !out_valid_r, "reset did not idle the solver")
  `BTS_ASSERT(a_accept_busy, in_acc |=> (state_r != S_IDLE), "request taken but solver stayed idle")
  `BTS_ASSERT(a_done_in_wait, div_stat.done |-> (state_r == S_CHK_WAIT) || (state_r == S_TRY_WAIT), "divider finished outside a wait state")
  `BTS_ASSERT(a_busy_in_wait, div_stat.busy |-> (state_r == S_CHK_WAIT) || (state_r == S_TRY_WAIT), "divider running outside a wait state")
  `BTS_ASSERT(a_err_zero, out_valid_r && (out_status_r != ST_OK) |-> (out_cfg_word_r == 19'd0) && (out_prescaler_r == 7'd0), "error word carries timing fields")
  `BTS_ASSERT(a_ok_quanta, out_valid_r && (out_status_r == ST_OK) |-> (out_q_r >= 5'd11) && (out_q_r <= 5'd19), "quanta count outside legal split range")

endmodule

`default_nettype wire
